### rtl/core/i2cram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam logic [7:0] MSB_MASK = 8'h80;

  // item kinds carried on tuser
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_QUEUE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_PHASE = 2'd1;

  // frame steps inside one transaction
  localparam logic [1:0] FS_ADDR_W = 2'd0;
  localparam logic [1:0] FS_REG    = 2'd1;
  localparam logic [1:0] FS_ADDR_R = 2'd2;
  localparam logic [1:0] FS_DATA_W = 2'd3;

  typedef enum logic [15:0] {
    PH_IDLE  = 16'h0001,
    PH_ST_A  = 16'h0002,
    PH_ST_B  = 16'h0004,
    PH_ST_C  = 16'h0008,
    PH_TX_LO = 16'h0010,
    PH_TX_HI = 16'h0020,
    PH_AK_LO = 16'h0040,
    PH_AK_HI = 16'h0080,
    PH_RX_LO = 16'h0100,
    PH_RX_HI = 16'h0200,
    PH_MA_LO = 16'h0400,
    PH_MA_HI = 16'h0800,
    PH_RS_A  = 16'h1000,
    PH_SP_A  = 16'h2000,
    PH_SP_B  = 16'h4000,
    PH_SP_C  = 16'h8000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_sample;
    logic [7:0] byte_value;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [4:0] length;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic       nack_error;
  } result_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [9:0] ticks_per_phase;
  } cfg_t;

endpackage

### rtl/core/i2cram_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_engine
// Bus phase sequencer, write queue and transaction state; one item per step.
// ----------------------------------------------------------------------------
module i2cram_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cram_pkg::item_t item,
  input  i2cram_pkg::cfg_t  cfg,
  output i2cram_pkg::result_t res
);
  import i2cram_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [9:0] ticks_r, ticks_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [4:0] bidx_r, bidx_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [4:0] fill_r, fill_nxt;
  logic [7:0] hreg_r, hreg_nxt;
  logic [4:0] hlen_r, hlen_nxt;
  logic       hdir_r, hdir_nxt;
  logic [1:0] fstep_r, fstep_nxt;
  logic       perr_r, perr_nxt;

  logic [7:0] queue [QUEUE_DEPTH];
  logic [7:0] q_rd_r;
  logic       q_we;

  logic [9:0] limit;
  logic [9:0] ticks_inc;
  logic [3:0] bit_inc;
  logic [5:0] bidx_inc;
  logic       ackbit;
  logic [4:0] lw_idx;
  logic [7:0] tx_shifted;
  logic [7:0] rx_shifted;
  logic [4:0] start_len;

  // queue is only written while idle; the entry for the next write byte is
  // read ahead, and index and contents hold for a whole byte time
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue[fill_r[QIDX_W-1:0]] <= item.byte_value;
    end
    q_rd_r <= queue[lw_idx[QIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      bit_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      fill_r  <= '0;
      hreg_r  <= '0;
      hlen_r  <= '0;
      hdir_r  <= 1'b0;
      fstep_r <= FS_ADDR_W;
      perr_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      bit_r   <= bit_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      fill_r  <= fill_nxt;
      hreg_r  <= hreg_nxt;
      hlen_r  <= hlen_nxt;
      hdir_r  <= hdir_nxt;
      fstep_r <= fstep_nxt;
      perr_r  <= perr_nxt;
    end
  end

  assign limit      = (cfg.ticks_per_phase == '0) ? 10'd1 : cfg.ticks_per_phase;
  assign ticks_inc  = ticks_r + 10'd1;
  assign bit_inc    = bit_r + 4'd1;
  assign bidx_inc   = {1'b0, bidx_r} + 6'd1;
  assign ackbit     = (bidx_inc >= {1'b0, hlen_r});
  assign tx_shifted = {shift_r[6:0], 1'b0};
  assign rx_shifted = {shift_r[6:0], item.sda_sample};
  assign lw_idx     = (fstep_r == FS_REG) ? 5'd0 : bidx_inc[4:0];
  assign start_len  = (!item.is_read && item.length > 5'(QUEUE_DEPTH)) ?
                      5'(QUEUE_DEPTH) : item.length;
  assign q_we       = step && (item.kind == KIND_QUEUE) && (phase_r == PH_IDLE) &&
                      (fill_r < 5'(QUEUE_DEPTH));

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    bit_nxt   = bit_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    fill_nxt  = fill_r;
    hreg_nxt  = hreg_r;
    hlen_nxt  = hlen_r;
    hdir_nxt  = hdir_r;
    fstep_nxt = fstep_r;
    perr_nxt  = perr_r;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.read_valid = 1'b0;
    res.read_byte  = '0;
    res.last_byte  = 1'b0;
    res.done_res   = 1'b0;
    res.nack_error = 1'b0;

    // line drive comes from the phase held before this item
    case (phase_r)
      PH_ST_B:  res.sda_level = 1'b0;
      PH_ST_C:  begin res.scl_level = 1'b0; res.sda_level = 1'b0; end
      PH_TX_LO: begin res.scl_level = 1'b0; res.sda_level = |(shift_r & MSB_MASK); end
      PH_TX_HI: res.sda_level = |(shift_r & MSB_MASK);
      PH_AK_LO: res.scl_level = 1'b0;
      PH_RX_LO: res.scl_level = 1'b0;
      PH_RS_A:  res.scl_level = 1'b0;
      PH_MA_LO: begin res.scl_level = 1'b0; res.sda_level = ackbit; end
      PH_MA_HI: res.sda_level = ackbit;
      PH_SP_A:  begin res.scl_level = 1'b0; res.sda_level = 1'b0; end
      PH_SP_B:  res.sda_level = 1'b0;
      default:  ;
    endcase

    case (item.kind)
      KIND_QUEUE: begin
        if (q_we) fill_nxt = fill_r + 5'd1;
      end
      KIND_START: begin
        if (phase_r == PH_IDLE) begin
          hdir_nxt  = item.is_read;
          hreg_nxt  = item.reg_addr;
          hlen_nxt  = start_len;
          if (!item.is_read) fill_nxt = '0;
          bidx_nxt  = '0;
          bit_nxt   = '0;
          fstep_nxt = FS_ADDR_W;
          perr_nxt  = 1'b0;
          shift_nxt = {cfg.device_address, 1'b0};
          phase_nxt = PH_ST_A;
          ticks_nxt = '0;
        end
      end
      KIND_TICK: begin
        if (phase_r != PH_IDLE) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= limit) begin
            ticks_nxt = '0;
            case (phase_r)
              PH_ST_A:  phase_nxt = PH_ST_B;
              PH_ST_B:  phase_nxt = PH_ST_C;
              PH_ST_C:  begin bit_nxt = '0; phase_nxt = PH_TX_LO; end
              PH_TX_LO: phase_nxt = PH_TX_HI;
              PH_TX_HI: begin
                shift_nxt = tx_shifted;
                bit_nxt   = bit_inc;
                phase_nxt = (bit_inc >= 4'd8) ? PH_AK_LO : PH_TX_LO;
              end
              PH_AK_LO: phase_nxt = PH_AK_HI;
              PH_AK_HI: begin
                case (fstep_r)
                  FS_ADDR_W: begin
                    if (item.sda_sample) begin
                      perr_nxt  = 1'b1;
                      phase_nxt = PH_SP_A;
                    end else begin
                      fstep_nxt = FS_REG;
                      shift_nxt = hreg_r;
                      bit_nxt   = '0;
                      phase_nxt = PH_TX_LO;
                    end
                  end
                  FS_ADDR_R: begin
                    bidx_nxt = '0;
                    if (hlen_r != '0) begin
                      shift_nxt = '0;
                      bit_nxt   = '0;
                      phase_nxt = PH_RX_LO;
                    end else begin
                      phase_nxt = PH_SP_A;
                    end
                  end
                  default: begin
                    // register ack (write path) or data ack share the queue fetch
                    if (fstep_r == FS_REG && hdir_r) begin
                      fstep_nxt = FS_ADDR_R;
                      shift_nxt = {cfg.device_address, 1'b1};
                      phase_nxt = PH_RS_A;
                    end else if (fstep_r == FS_DATA_W && item.sda_sample) begin
                      perr_nxt  = 1'b1;
                      phase_nxt = PH_SP_A;
                    end else begin
                      fstep_nxt = FS_DATA_W;
                      bidx_nxt  = lw_idx;
                      if (lw_idx < hlen_r && lw_idx < 5'(QUEUE_DEPTH)) begin
                        shift_nxt = q_rd_r;
                        bit_nxt   = '0;
                        phase_nxt = PH_TX_LO;
                      end else begin
                        phase_nxt = PH_SP_A;
                      end
                    end
                  end
                endcase
              end
              PH_RX_LO: phase_nxt = PH_RX_HI;
              PH_RX_HI: begin
                shift_nxt = rx_shifted;
                bit_nxt   = bit_inc;
                if (bit_inc >= 4'd8) begin
                  res.read_valid = 1'b1;
                  res.read_byte  = rx_shifted;
                  res.last_byte  = ackbit;
                  phase_nxt      = PH_MA_LO;
                end else begin
                  phase_nxt = PH_RX_LO;
                end
              end
              PH_MA_LO: phase_nxt = PH_MA_HI;
              PH_MA_HI: begin
                bidx_nxt = bidx_inc[4:0];
                if (bidx_inc[4:0] < hlen_r) begin
                  shift_nxt = '0;
                  bit_nxt   = '0;
                  phase_nxt = PH_RX_LO;
                end else begin
                  phase_nxt = PH_SP_A;
                end
              end
              PH_RS_A: phase_nxt = PH_ST_A;
              PH_SP_A: phase_nxt = PH_SP_B;
              PH_SP_B: phase_nxt = PH_SP_C;
              PH_SP_C: begin
                res.done_res   = 1'b1;
                res.nack_error = perr_r;
                perr_nxt       = 1'b0;
                phase_nxt      = PH_IDLE;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase

    res.busy_res = (phase_nxt != PH_IDLE);
  end

endmodule

### rtl/core/i2c_register_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master for register writes and reads on a single slave, driven by
// a stream of tick, queue-byte and start items.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser = kind (tick, queue byte, start).
//           Ticks carry the sampled SDA level and advance the bus sequencer.
//   out_* : exactly one result per accepted item, in order, carrying the
//           SCL/SDA drive, busy, received byte and done/NACK flags.
//           out_tlast marks the final received byte of a read.
//   cfg_* : register writes (index 0 device address, 1 ticks per phase),
//           always ready; write only while no transaction is running.
// Path: an accepted item lands in the input register, is processed there
//   by the engine as it moves on, and its result is registered in the output
//   register, which drives out_*.
// Throughput: one item per cycle; the input register and the output
//   register each hold while the next stage is stalled, so a stalled
//   receiver backs up into in_tready only once both are full.
// Reset (rst_n low, synchronous): sequencer idle, queue empty, config back
//   to address 104 and four ticks per phase. Queue contents are not cleared.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sda_sample, byte_value[8], is_read,
                                  // reg_addr[8], length[5], pad
  input  logic [1:0]  in_tuser,   // kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level, sda_level, busy_res, read_valid,
                                  // read_byte[8], done_res, nack_error, pad
  output logic        out_tlast,  // last_byte
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [9:0]  cfg_data
);
  import i2cram_pkg::*;

  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t out_res_r;
  cfg_t    cfg_r;
  result_t res;
  logic    advance;
  logic    in_fire;

  // input register moves on whenever the output register can take a result
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address  <= 7'd104;
      cfg_r.ticks_per_phase <= 10'd4;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_DEVICE_ADDRESS:  cfg_r.device_address  <= cfg_data[6:0];
        CFG_TICKS_PER_PHASE: cfg_r.ticks_per_phase <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.kind       <= in_tuser;
      in_item_r.sda_sample <= in_tdata[0];
      in_item_r.byte_value <= in_tdata[8:1];
      in_item_r.is_read    <= in_tdata[9];
      in_item_r.reg_addr   <= in_tdata[17:10];
      in_item_r.length     <= in_tdata[22:18];
    end
  end

  i2cram_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_res_r.last_byte;
  assign out_tdata  = {2'b00,
                       out_res_r.nack_error,
                       out_res_r.done_res,
                       out_res_r.read_byte,
                       out_res_r.read_valid,
                       out_res_r.busy_res,
                       out_res_r.sda_level,
                       out_res_r.scl_level};

endmodule
